// ===== src/tcce_pkg.sv =====
`default_nettype none

package tcce_pkg;

    // default geometry of the text store
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // function codes of an input item
    localparam logic [1:0] FUNC_PRINT = 2'd0;
    localparam logic [1:0] FUNC_ECHO  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // character codes with special meaning
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // attribute used by the clearing pass after reset and reset value of the register
    localparam logic [7:0] RESET_ATTR = 8'h07;

    // class of an input item
    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_CHAR,
        OP_NEWLINE,
        OP_BACK
    } in_op_t;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCROLL_PRIME,
        S_SCROLL,
        S_BLANK,
        S_RESULT
    } state_t;

    // cursor update
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_BACK
    } cur_op_t;

    // store write source
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CHAR,
        WR_ERASE,
        WR_BLANK,
        WR_CLEAR,
        WR_SCROLL
    } wr_sel_t;

    // sweep pointer update
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_ZERO,
        PTR_NEXT_ROW,
        PTR_THIS_ROW
    } ptr_op_t;

    // store read address source
    typedef enum logic [1:0] {
        RD_INPUT,
        RD_HELD,
        RD_SCROLL
    } rd_sel_t;

    typedef struct packed {
        cur_op_t cur;
        wr_sel_t wr;
        ptr_op_t ptr;
        rd_sel_t rd;
        logic    latch;
        logic    out_load;
    } tcce_cmd_t;

    typedef struct packed {
        in_op_t op;
        logic   col_last;
        logic   col_zero;
        logic   row_last;
        logic   scroll_end;
        logic   sweep_col_last;
        logic   clear_end;
    } tcce_stat_t;

endpackage

`default_nettype wire

// ===== src/text_console_cursor_engine.sv =====
// print, echo, read and no-op go from idle to the result state, whose output register loads
// once the receiver is free; newline, line wrap and backspace at column 0 blank one row first
// a scroll walks the store through one read and one write port
// items do not overlap: in_ready is high only in the idle state, after the previous result is loaded
// reset: cursor to home, fill attribute 7, then a clearing pass over all COLUMNS * ROWS cells
// (2000 at 80 x 25) writes spaces into the store while in_ready stays low
`default_nettype none

module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // fill attribute register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  fill_attribute,

    // input items
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  char_code,
    input  wire logic [10:0] cell_index,

    // result items
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [6:0]       cursor_col,
    output logic [4:0]       cursor_row,
    output logic [10:0]      cursor_location,
    output logic [7:0]       read_char,
    output logic [7:0]       read_attr
);

    // commands from the controller, status back from the datapath
    tcce_cmd_t  cmd;
    tcce_stat_t stat;

    // controller: sequences clearing pass, item decode, row blanking, scrolling
    // and the result register; an input transfer is taken only in the idle state
    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: cursor registers, sweep pointer, the text store with its
    // registered read port, and the result register that holds one transfer
    tcce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .fill_attribute  (fill_attribute),
        .func            (func),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_location (cursor_location),
        .read_char       (read_char),
        .read_attr       (read_attr),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

`default_nettype wire

// ===== src/tcce_ctrl.sv =====
`default_nettype none

module tcce_ctrl
    import tcce_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire tcce_stat_t stat,
    output tcce_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (stat.op)
                        OP_NONE, OP_READ:
                        begin
                            state_next = S_RESULT;
                        end
                        OP_CHAR, OP_NEWLINE:
                        begin
                            if (stat.op == OP_CHAR && !stat.col_last)
                            begin
                                state_next = S_RESULT;
                            end
                            else if (stat.row_last)
                            begin
                                state_next = S_SCROLL_PRIME;
                            end
                            else
                            begin
                                state_next = S_BLANK;
                            end
                        end
                        OP_BACK:
                        begin
                            state_next = stat.col_zero ? S_BLANK : S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCROLL_PRIME:
            begin
                state_next = S_SCROLL;
            end
            S_SCROLL:
            begin
                if (stat.scroll_end)
                begin
                    state_next = S_BLANK;
                end
            end
            S_BLANK:
            begin
                if (stat.sweep_col_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd.cur      = CUR_HOLD;
        cmd.wr       = WR_NONE;
        cmd.ptr      = PTR_HOLD;
        cmd.rd       = RD_HELD;
        cmd.latch    = 1'b0;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.wr  = WR_CLEAR;
                cmd.ptr = PTR_INC;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.rd   = RD_INPUT;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    unique case (stat.op)
                        OP_NONE, OP_READ:
                        begin
                            cmd.cur = CUR_HOLD;
                        end
                        OP_CHAR, OP_NEWLINE:
                        begin
                            if (stat.op == OP_CHAR)
                            begin
                                cmd.wr = WR_CHAR;
                            end
                            if (stat.op == OP_CHAR && !stat.col_last)
                            begin
                                cmd.cur = CUR_ADVANCE;
                            end
                            else
                            begin
                                cmd.cur = CUR_NEWLINE;
                                cmd.ptr = stat.row_last ? PTR_ZERO : PTR_NEXT_ROW;
                            end
                        end
                        OP_BACK:
                        begin
                            cmd.wr  = WR_ERASE;
                            cmd.cur = CUR_BACK;
                            if (stat.col_zero)
                            begin
                                cmd.ptr = PTR_THIS_ROW;
                            end
                        end
                        default:
                        begin
                            cmd.cur = CUR_HOLD;
                        end
                    endcase
                end
            end
            S_SCROLL_PRIME:
            begin
                cmd.rd = RD_SCROLL;
            end
            S_SCROLL:
            begin
                cmd.rd  = RD_SCROLL;
                cmd.wr  = WR_SCROLL;
                cmd.ptr = PTR_INC;
            end
            S_BLANK:
            begin
                cmd.wr  = WR_BLANK;
                cmd.ptr = PTR_INC;
            end
            S_RESULT:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.rd = RD_HELD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // the store is left alone while waiting for an item
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !in_valid) |-> (cmd.wr == WR_NONE))
        else $error("store written while idle");

    // no result before the clearing pass is over
    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("result during clearing pass");

endmodule

`default_nettype wire

// ===== src/tcce_datapath.sv =====
`default_nettype none

module tcce_datapath
    import tcce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  fill_attribute,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  char_code,
    input  wire logic [10:0] cell_index,
    output logic [6:0]       cursor_col,
    output logic [4:0]       cursor_row,
    output logic [10:0]      cursor_location,
    output logic [7:0]       read_char,
    output logic [7:0]       read_attr,
    input  wire tcce_cmd_t   cmd,
    output tcce_stat_t       stat
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELLS_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W:0]   CELLS_W     = (ADDR_W + 1)'(CELLS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

    logic [15:0]       text_mem [CELLS];
    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              wr_en;

    logic [7:0]        fill_attr_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [COL_W-1:0]  sweep_col_reg;
    logic [COL_W-1:0]  sweep_col_next;
    logic [ADDR_W-1:0] held_addr_reg;
    logic              read_flag_reg;

    logic [6:0]        cursor_col_reg;
    logic [4:0]        cursor_row_reg;
    logic [10:0]       cursor_location_reg;
    logic [7:0]        read_char_reg;
    logic [7:0]        read_attr_reg;

    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] loc;
    logic [ADDR_W-1:0] erase_addr;
    logic [ADDR_W:0]   scroll_rd_wide;
    logic [ADDR_W-1:0] scroll_rd;
    logic              cell_ok;
    logic [ADDR_W-1:0] in_rd_addr;
    logic              is_newline;
    in_op_t            op;

    assign cfg_ready = 1'b1;

    // item class
    assign is_newline = (char_code == CHAR_LF) || (char_code == CHAR_CR);

    always_comb
    begin
        unique case (func)
            FUNC_PRINT:
            begin
                op = is_newline ? OP_NEWLINE : OP_CHAR;
            end
            FUNC_ECHO:
            begin
                if (char_code == CHAR_NUL)
                begin
                    op = OP_NONE;
                end
                else if (is_newline)
                begin
                    op = OP_NEWLINE;
                end
                else if (char_code == CHAR_BS)
                begin
                    op = OP_BACK;
                end
                else
                begin
                    op = OP_CHAR;
                end
            end
            FUNC_READ:
            begin
                op = OP_READ;
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    // cursor address arithmetic
    assign row_base   = ADDR_W'(row_reg) * COLS_A;
    assign loc        = row_base + ADDR_W'(col_reg);
    assign erase_addr = (loc == '0) ? '0 : loc - 1'b1;

    assign cell_ok    = 32'(cell_index) < 32'(CELLS);
    assign in_rd_addr = cell_ok ? ADDR_W'(cell_index) : '0;

    assign stat.op             = op;
    assign stat.col_last       = (col_reg == LAST_COL);
    assign stat.col_zero       = (col_reg == '0);
    assign stat.row_last       = (row_reg == LAST_ROW);
    assign stat.scroll_end     = (ptr_reg == SCROLL_LAST);
    assign stat.sweep_col_last = (sweep_col_reg == LAST_COL);
    assign stat.clear_end      = (ptr_reg == CELLS_LAST);

    // cursor update
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        unique case (cmd.cur)
            CUR_HOLD:
            begin
                col_next = col_reg;
            end
            CUR_ADVANCE:
            begin
                col_next = col_reg + 1'b1;
            end
            CUR_NEWLINE:
            begin
                col_next = '0;
                if (!stat.row_last)
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            CUR_BACK:
            begin
                if (!stat.col_zero)
                begin
                    col_next = col_reg - 1'b1;
                end
                else if (row_reg != '0)
                begin
                    col_next = LAST_COL;
                    row_next = row_reg - 1'b1;
                end
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    // sweep pointer for clearing, blanking and scrolling
    always_comb
    begin
        ptr_next       = ptr_reg;
        sweep_col_next = sweep_col_reg;
        unique case (cmd.ptr)
            PTR_HOLD:
            begin
                ptr_next = ptr_reg;
            end
            PTR_INC:
            begin
                ptr_next       = ptr_reg + 1'b1;
                sweep_col_next = stat.sweep_col_last ? '0 : sweep_col_reg + 1'b1;
            end
            PTR_ZERO:
            begin
                ptr_next       = '0;
                sweep_col_next = '0;
            end
            PTR_NEXT_ROW:
            begin
                ptr_next       = row_base + COLS_A;
                sweep_col_next = '0;
            end
            PTR_THIS_ROW:
            begin
                ptr_next       = row_base;
                sweep_col_next = '0;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // scroll reads run one row ahead of the write pointer
    assign scroll_rd_wide = {1'b0, ptr_next} + {1'b0, COLS_A};
    assign scroll_rd      = (scroll_rd_wide < CELLS_W) ? scroll_rd_wide[ADDR_W-1:0] : '0;

    always_comb
    begin
        unique case (cmd.rd)
            RD_INPUT:  rd_addr = in_rd_addr;
            RD_HELD:   rd_addr = held_addr_reg;
            RD_SCROLL: rd_addr = scroll_rd;
            default:   rd_addr = held_addr_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = ptr_reg;
        wr_data = {fill_attr_reg, CHAR_SPACE};
        unique case (cmd.wr)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_CHAR:
            begin
                wr_addr = loc;
                wr_data = {fill_attr_reg, char_code};
            end
            WR_ERASE:
            begin
                wr_addr = erase_addr;
            end
            WR_BLANK:
            begin
                wr_addr = ptr_reg;
            end
            WR_CLEAR:
            begin
                wr_data = {RESET_ATTR, CHAR_SPACE};
            end
            WR_SCROLL:
            begin
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= text_mem[rd_addr];
        if (wr_en)
        begin
            text_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_attr_reg <= RESET_ATTR;
            col_reg       <= '0;
            row_reg       <= '0;
            ptr_reg       <= '0;
            sweep_col_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                fill_attr_reg <= fill_attribute;
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            ptr_reg       <= ptr_next;
            sweep_col_reg <= sweep_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            held_addr_reg <= in_rd_addr;
            read_flag_reg <= (op == OP_READ) && cell_ok;
        end
        if (cmd.out_load)
        begin
            cursor_col_reg      <= 7'(col_reg);
            cursor_row_reg      <= 5'(row_reg);
            cursor_location_reg <= 11'(loc);
            read_char_reg       <= read_flag_reg ? rd_data_reg[7:0] : 8'h00;
            read_attr_reg       <= read_flag_reg ? rd_data_reg[15:8] : 8'h00;
        end
    end

    assign cursor_col      = cursor_col_reg;
    assign cursor_row      = cursor_row_reg;
    assign cursor_location = cursor_location_reg;
    assign read_char       = read_char_reg;
    assign read_attr       = read_attr_reg;

    // cursor always inside the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= LAST_COL) && (row_reg <= LAST_ROW))
        else $error("cursor outside the screen");

    // scroll copies never reach the bottom row
    a_scroll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr == WR_SCROLL) |-> (ptr_reg <= SCROLL_LAST))
        else $error("scroll write past the last copied cell");

endmodule

`default_nettype wire

// ===== sim/tb_text_console_cursor_engine.sv =====
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
    import tcce_pkg::*;

    // geometry of the text store under test
    localparam int NCOL  = DEF_COLUMNS;
    localparam int NROW  = DEF_ROWS;
    localparam int NCELL = NCOL * NROW;

    // func value 3 has no name in the package, the block treats it as a no-op
    localparam logic [1:0] FUNC_NOP = 2'd3;

    // long receiver hold-off used to back the block up
    localparam int HOLD_CYCLES = 300;

    // one result transfer as seen on the output port
    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] loc;
        logic [7:0]  rchar;
        logic [7:0]  rattr;
    } cursor_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  fill_attribute;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_location;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;

    // shadow copy of the console: store, cursor and fill attribute
    logic [15:0] screen_mem [0:NCELL-1];
    int unsigned cur_col;
    int unsigned cur_row;
    logic [7:0]  shadow_fill;

    // results predicted for accepted items, oldest first
    cursor_result_t cursor_reports [$];

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;

    // receiver hold-off control
    event rx_hold_start;
    logic rx_hold;

    int err_count;
    int result_count;

    text_console_cursor_engine dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .fill_attribute  (fill_attribute),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_location (cursor_location),
        .read_char       (read_char),
        .read_attr       (read_attr)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // console predictor
    // ---------------------------------------------------------------

    // store a character with the current fill attribute, out of range is dropped
    function automatic void mem_put(input int unsigned idx, input logic [7:0] ch);
        if (idx < NCELL)
            screen_mem[idx] = {shadow_fill, ch};
    endfunction

    // a blanked cell is a space in the current fill attribute
    function automatic void blank_line(input int unsigned r);
        if (r >= NROW)
            return;
        for (int c = 0; c < NCOL; c++)
            mem_put(r * NCOL + c, CHAR_SPACE);
    endfunction

    // every row moves up one, bottom row blanked, cursor to start of bottom row
    function automatic void scroll_screen();
        for (int i = 0; i < (NROW - 1) * NCOL; i++)
            screen_mem[i] = screen_mem[i + NCOL];
        cur_col = 0;
        cur_row = NROW - 1;
        blank_line(NROW - 1);
    endfunction

    // start of the next row, scrolling off the bottom, and the new row blanked
    function automatic void line_feed();
        cur_row++;
        if (cur_row >= NROW)
            scroll_screen();
        blank_line(cur_row);
        cur_col = 0;
    endfunction

    function automatic void put_char(input logic [7:0] ch);
        mem_put(cur_row * NCOL + cur_col, ch);
        cur_col++;
        if (cur_col >= NCOL)
            line_feed();
    endfunction

    // destructive backspace; at column 0 the current row is blanked first and
    // the cursor steps back to the end of the row above, home stays home
    function automatic void rub_out();
        if (cur_col == 0)
        begin
            blank_line(cur_row);
            if (cur_row != 0)
            begin
                cur_col = NCOL - 1;
                cur_row--;
            end
        end
        else
        begin
            cur_col--;
        end
        mem_put(cur_row * NCOL + cur_col, CHAR_SPACE);
    endfunction

    // apply one item to the shadow console and return the result it gives
    function automatic cursor_result_t console_step(input logic [1:0] f,
                                                    input logic [7:0] ch,
                                                    input logic [10:0] idx);
        cursor_result_t r;
        int unsigned pos;
        r = '0;
        if (f == FUNC_PRINT || (f == FUNC_ECHO && ch != CHAR_NUL))
        begin
            // cursor past the last cell scrolls before anything else
            if (cur_row * NCOL + cur_col >= NCELL)
                scroll_screen();
            if (ch == CHAR_LF || ch == CHAR_CR)
                line_feed();
            else if (f == FUNC_ECHO && ch == CHAR_BS)
                rub_out();
            else
                put_char(ch);
        end
        else if (f == FUNC_READ && idx < NCELL)
        begin
            r.rchar = screen_mem[idx][7:0];
            r.rattr = screen_mem[idx][15:8];
        end
        pos = (cur_row * NCOL + cur_col) % NCELL;
        r.col = 7'(cur_col);
        r.row = 5'(cur_row);
        r.loc = 11'(pos);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // character mix with the control codes well represented
    function automatic logic [7:0] random_char();
        int p;
        p = $urandom_range(0, 99);
        if (p < 4)
            return CHAR_LF;
        else if (p < 7)
            return CHAR_CR;
        else if (p < 15)
            return CHAR_BS;
        else if (p < 19)
            return CHAR_NUL;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // reads mostly land near the cursor where the text is fresh
    function automatic logic [10:0] random_cell();
        int p;
        int unsigned r;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 11'(cur_row * NCOL + $urandom_range(0, NCOL - 1));
        if (p < 60)
        begin
            r = (cur_row == 0) ? 0 : cur_row - 1;
            return 11'(r * NCOL + $urandom_range(0, NCOL - 1));
        end
        if (p < 85)
            return 11'($urandom_range(0, NCELL - 1));
        // whole field range, out-of-range indexes included
        return 11'($urandom_range(0, 2047));
    endfunction

    // offer one item, wait for its transfer, record the predicted result;
    // valid stays high afterwards so a back-to-back item needs no gap
    task automatic send_item(input logic [1:0] f, input logic [7:0] ch,
                             input logic [10:0] idx);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid   <= 1'b1;
            func       <= f;
            char_code  <= ch;
            cell_index <= idx;
            do
                @(posedge clk);
            while (!in_ready);
            cursor_reports.push_back(console_step(f, ch, idx));
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            while (cursor_reports.size() != 0)
                @(posedge clk);
        end
    endtask

    // fill attribute register write, only called with the block idle
    task automatic write_fill(input logic [7:0] attr);
        begin
            cfg_valid      <= 1'b1;
            fill_attribute <= attr;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid   <= 1'b0;
            shadow_fill = attr;
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // store contents after the clearing pass, every func, control codes and
    // the backspace corner cases, all with the reset fill attribute
    task automatic test_corners();
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            // cleared store at both ends, then indexes past the last cell
            send_item(FUNC_READ, 8'h00, 11'd0);
            send_item(FUNC_READ, 8'hFF, 11'(NCELL - 1));
            send_item(FUNC_READ, 8'h00, 11'(NCELL));
            send_item(FUNC_READ, 8'h00, 11'h7FF);
            // unused func and echo of nul change nothing
            send_item(FUNC_NOP, 8'hFF, 11'h7FF);
            send_item(FUNC_ECHO, CHAR_NUL, 11'd0);
            // backspace at home blanks row 0 and stays put
            send_item(FUNC_ECHO, CHAR_BS, 11'd0);
            // print stores backspace and nul as plain characters
            send_item(FUNC_PRINT, CHAR_BS, 11'd0);
            send_item(FUNC_PRINT, 8'hFF, 11'd0);
            send_item(FUNC_PRINT, CHAR_NUL, 11'd0);
            send_item(FUNC_PRINT, CHAR_LF, 11'd0);
            send_item(FUNC_PRINT, CHAR_CR, 11'd0);
            // echo a character, rub it out, then back over the row boundary
            send_item(FUNC_ECHO, 8'h41, 11'd0);
            send_item(FUNC_ECHO, CHAR_BS, 11'd0);
            send_item(FUNC_ECHO, CHAR_BS, 11'd0);
            send_item(FUNC_READ, 8'h00, 11'(2 * NCOL - 1));
            send_item(FUNC_ECHO, CHAR_LF, 11'd0);
            send_item(FUNC_ECHO, CHAR_CR, 11'd0);
            // the three characters printed on row 0
            send_item(FUNC_READ, 8'h00, 11'd0);
            send_item(FUNC_READ, 8'h00, 11'd1);
            send_item(FUNC_READ, 8'h00, 11'd2);
            wait_idle();
        end
    endtask

    // receiver holds off for a long stretch while items keep coming, so the
    // block fills up and drops in_ready
    task automatic test_backpressure();
        begin
            wait_idle();
            write_fill(8'($urandom_range(1, 254)));
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            -> rx_hold_start;
            for (int i = 0; i < 40; i++)
            begin
                if (i % 3 == 2)
                    send_item(FUNC_READ, random_char(), random_cell());
                else
                    send_item(FUNC_PRINT, random_char(), random_cell());
            end
            wait_idle();
        end
    endtask

    // random traffic under one fill attribute and one idling profile
    task automatic test_random_traffic(input int n_items, input int tx_idle,
                                       input int rx_stall, input logic [7:0] attr);
        int sent;
        int run_len;
        int p;
        begin
            wait_idle();
            write_fill(attr);
            send_idle_pct  = tx_idle;
            recv_stall_pct = rx_stall;
            sent = 0;
            while (sent < n_items)
            begin
                p = $urandom_range(0, 99);
                if (p < 3)
                begin
                    // a run of backspaces, long enough to walk back over rows
                    run_len = $urandom_range(1, 100);
                    repeat (run_len)
                        send_item(FUNC_ECHO, CHAR_BS, 11'($urandom_range(0, 2047)));
                    sent += run_len;
                end
                else
                begin
                    if (p < 36)
                        send_item(FUNC_PRINT, random_char(), 11'($urandom_range(0, 2047)));
                    else if (p < 65)
                        send_item(FUNC_ECHO, random_char(), 11'($urandom_range(0, 2047)));
                    else if (p < 95)
                        send_item(FUNC_READ, 8'($urandom_range(0, 255)), random_cell());
                    else
                        send_item(FUNC_NOP, 8'($urandom_range(0, 255)),
                                  11'($urandom_range(0, 2047)));
                    sent++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    // hold-off stretch, counted here so the sender is free to keep going
    initial
    begin
        rx_hold <= 1'b0;
        forever
        begin
            @(rx_hold_start);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // random stalls on out_ready
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge clk)
    begin
        cursor_result_t seen;
        cursor_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {cursor_col, cursor_row, cursor_location, read_char, read_attr};
            result_count++;
            if (cursor_reports.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result %0d: col %0d row %0d loc %0d char %h attr %h",
                             result_count, seen.col, seen.row, seen.loc,
                             seen.rchar, seen.rattr);
            end
            else
            begin
                want = cursor_reports.pop_front();
                if (seen.col !== want.col || seen.row !== want.row ||
                    seen.loc !== want.loc || seen.rchar !== want.rchar ||
                    seen.rattr !== want.rattr)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("result %0d mismatch at %0t", result_count, $realtime);
                        $display("  expected col %0d row %0d loc %0d char %h attr %h",
                                 want.col, want.row, want.loc, want.rchar, want.rattr);
                        $display("  actual   col %0d row %0d loc %0d char %h attr %h",
                                 seen.col, seen.row, seen.loc, seen.rchar, seen.rattr);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------

    initial
    begin
        err_count      = 0;
        result_count   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // shadow console as the block comes out of its clearing pass
        for (int i = 0; i < NCELL; i++)
            screen_mem[i] = {RESET_ATTR, CHAR_SPACE};
        cur_col     = 0;
        cur_row     = 0;
        shadow_fill = RESET_ATTR;

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        fill_attribute <= RESET_ATTR;
        in_valid       <= 1'b0;
        func           <= FUNC_PRINT;
        char_code      <= CHAR_NUL;
        cell_index     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the clearing pass holds in_ready low, send_item just waits it out
        test_corners();
        test_backpressure();
        // no idling, then sender gaps, receiver stalls, and both
        test_random_traffic(475, 0, 0, 8'hFF);
        test_random_traffic(475, 86, 0, 8'h00);
        test_random_traffic(475, 0, 86, 8'($urandom_range(0, 255)));
        test_random_traffic(475, 34, 34, 8'($urandom_range(0, 255)));

        wait_idle();
        // room for a stray result after a full scroll
        recv_stall_pct = 0;
        repeat (NCELL + 4) @(posedge clk);

        if (err_count == 0 && cursor_reports.size() == 0)
            $display("tb_text_console_cursor_engine: done, clean");
        else
            $display("tb_text_console_cursor_engine: done, errors");
        $finish;
    end

    // watchdog: ~2000 items, each with a full scroll plus stalls and gaps,
    // is about 85 ms, allowed several times over
    initial
    begin
        #400_000_000;
        $display("tb_text_console_cursor_engine: done, errors");
        $finish;
    end

endmodule
